/* design/pfd_pkg.sv */
// pfd_pkg: types, register codes, microcode program and fixed-point helpers
// shared by the sequencer, the datapath and the top level of the filtered
// derivative controller; depends on nothing else
package pfd_pkg;

	localparam int DATA_W  = 32;
	localparam int PROD_W  = 2 * DATA_W;
	localparam int FRAC_W  = 16;
	localparam int CFG_IDX_W = 3;
	localparam int STEP_W  = 3;

	// configuration register codes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETPOINT   = 3'd0,
		REG_PROP_GAIN  = 3'd1,
		REG_DIN_GAIN   = 3'd2,
		REG_DFILT_GAIN = 3'd3,
		REG_INTEG_GAIN = 3'd4
	} reg_idx_t;

	// multiplier operand selects
	typedef enum logic [1:0] {
		A_ERR   = 2'd0,
		A_DELTA = 2'd1,
		A_PRE   = 2'd2
	} mul_a_t;

	typedef enum logic [1:0] {
		B_KP  = 2'd0,
		B_KD1 = 2'd1,
		B_KI  = 2'd2,
		B_KD2 = 2'd3
	} mul_b_t;

	// sequencing: next step, hold until a request arrives, or finish and restart once the output is free
	typedef enum logic [1:0] {
		J_NEXT    = 2'd0,
		J_WAIT_IN = 2'd1,
		J_END     = 2'd2
	} jump_t;

	typedef struct packed {
		jump_t  jmp;
		logic   load;
		logic   mul_en;
		mul_a_t a_sel;
		mul_b_t b_sel;
		logic   wr_p;
		logic   wr_pre;
		logic   wr_ii;
		logic   fin;
	} ctrl_word_t;

	typedef struct packed {
		logic out_busy;
	} dp_status_t;

	// step names of the program
	localparam logic [STEP_W-1:0] ST_LOAD  = 3'd0;
	localparam logic [STEP_W-1:0] ST_MULP  = 3'd1;
	localparam logic [STEP_W-1:0] ST_MULD1 = 3'd2;
	localparam logic [STEP_W-1:0] ST_MULI  = 3'd3;
	localparam logic [STEP_W-1:0] ST_MULD2 = 3'd4;
	localparam logic [STEP_W-1:0] ST_FIN   = 3'd5;

	// microcode table: one control word per step
	function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
		ctrl_word_t w;
		w = '{jmp: J_NEXT, load: 1'b0, mul_en: 1'b0, a_sel: A_ERR, b_sel: B_KP,
			wr_p: 1'b0, wr_pre: 1'b0, wr_ii: 1'b0, fin: 1'b0};
		unique case (step)
			ST_LOAD: begin
				w.jmp  = J_WAIT_IN;
				w.load = 1'b1;
			end
			ST_MULP: begin
				w.mul_en = 1'b1;
				w.a_sel  = A_ERR;
				w.b_sel  = B_KP;
			end
			ST_MULD1: begin
				w.mul_en = 1'b1;
				w.a_sel  = A_DELTA;
				w.b_sel  = B_KD1;
				w.wr_p   = 1'b1;
			end
			ST_MULI: begin
				w.mul_en = 1'b1;
				w.a_sel  = A_ERR;
				w.b_sel  = B_KI;
				w.wr_pre = 1'b1;
			end
			ST_MULD2: begin
				w.mul_en = 1'b1;
				w.a_sel  = A_PRE;
				w.b_sel  = B_KD2;
				w.wr_ii  = 1'b1;
			end
			ST_FIN: begin
				w.jmp = J_END;
				w.fin = 1'b1;
			end
			default: begin
				w.jmp = J_END;
			end
		endcase
		return w;
	endfunction

	// saturate a 34-bit exact sum to 32 bits
	function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [DATA_W+1:0] v);
		logic signed [DATA_W-1:0] r;
		if ((&v[DATA_W+1:DATA_W-1]) || !(|v[DATA_W+1:DATA_W-1]))
			r = v[DATA_W-1:0];
		else if (v[DATA_W+1])
			r = {1'b1, {(DATA_W-1){1'b0}}};
		else
			r = {1'b0, {(DATA_W-1){1'b1}}};
		return r;
	endfunction

	// drop the fraction bits of a full product (floor) and saturate
	function automatic logic signed [DATA_W-1:0] q_sat(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-FRAC_W-1:0] s;
		logic signed [DATA_W-1:0] r;
		s = p[PROD_W-1:FRAC_W];
		if ((&s[PROD_W-FRAC_W-1:DATA_W-1]) || !(|s[PROD_W-FRAC_W-1:DATA_W-1]))
			r = s[DATA_W-1:0];
		else if (s[PROD_W-FRAC_W-1])
			r = {1'b1, {(DATA_W-1){1'b0}}};
		else
			r = {1'b0, {(DATA_W-1){1'b1}}};
		return r;
	endfunction

endpackage

/* design/pfd_sequencer.sv */
// pfd_sequencer: step counter and microcode lookup with conditional jumps
// depends on pfd_pkg for the control word and the program table
module pfd_sequencer
	import pfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  dp_status_t status,
	output ctrl_word_t ctrl
);

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;

	// control word of the current step
	assign ctrl = ucode(step_q);

	// next step from the jump field
	always_comb begin
		step_d = step_q + 1'b1;
		unique case (ctrl.jmp)
			J_NEXT:    step_d = step_q + 1'b1;
			J_WAIT_IN: step_d = in_valid ? step_q + 1'b1 : step_q;
			J_END:     step_d = status.out_busy ? step_q : ST_LOAD;
			default:   step_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= ST_LOAD;
		else
			step_q <= step_d;
	end

endmodule

/* design/pfd_datapath.sv */
// pfd_datapath: configuration registers, shared multiplier, saturating adders,
// controller state and the output register; depends on pfd_pkg
module pfd_datapath
	import pfd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctrl_word_t               ctrl,
	output dp_status_t               status,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [DATA_W-1:0]        cfg_data,
	input  logic                     in_valid,
	input  logic signed [DATA_W-1:0] measured_speed,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] drive_value
);

	logic signed [DATA_W-1:0] setpoint_q, kp_q, kd1_q, kd2_q, ki_q;
	logic signed [DATA_W-1:0] deriv_q, integ_q, last_q;
	logic signed [DATA_W-1:0] speed_q, err_q, delta_q, p_q, pre_q, ii_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [DATA_W-1:0] drive_q;
	logic                     out_valid_q;

	logic signed [DATA_W-1:0] mul_a, mul_b, prod_frac;
	logic signed [PROD_W-1:0] prod_d;
	logic                     load_fire, out_fire;

	assign status.out_busy = out_valid_q && out_stall;
	assign load_fire = ctrl.load && in_valid;
	assign out_fire  = ctrl.fin && !status.out_busy;
	assign out_valid   = out_valid_q;
	assign drive_value = drive_q;

	// configuration writes, codes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= '0;
			kp_q       <= '0;
			kd1_q      <= '0;
			kd2_q      <= '0;
			ki_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SETPOINT:   setpoint_q <= cfg_data;
				REG_PROP_GAIN:  kp_q       <= cfg_data;
				REG_DIN_GAIN:   kd1_q      <= cfg_data;
				REG_DFILT_GAIN: kd2_q      <= cfg_data;
				REG_INTEG_GAIN: ki_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// operand selection for the shared multiplier
	always_comb begin
		case (ctrl.a_sel)
			A_ERR:   mul_a = err_q;
			A_DELTA: mul_a = delta_q;
			A_PRE:   mul_a = pre_q;
			default: mul_a = err_q;
		endcase
		case (ctrl.b_sel)
			B_KP:    mul_b = kp_q;
			B_KD1:   mul_b = kd1_q;
			B_KI:    mul_b = ki_q;
			B_KD2:   mul_b = kd2_q;
			default: mul_b = kp_q;
		endcase
	end

	assign prod_d    = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign prod_frac = q_sat(prod_q);

	// working registers, written as the program directs
	always_ff @(posedge clk) begin
		if (load_fire) begin
			speed_q <= measured_speed;
			err_q   <= sat_sum({{2{setpoint_q[DATA_W-1]}}, setpoint_q}
				- {{2{measured_speed[DATA_W-1]}}, measured_speed});
			delta_q <= sat_sum({{2{measured_speed[DATA_W-1]}}, measured_speed}
				- {{2{last_q[DATA_W-1]}}, last_q});
		end
		if (ctrl.mul_en)
			prod_q <= prod_d;
		if (ctrl.wr_p)
			p_q <= prod_frac;
		if (ctrl.wr_pre)
			pre_q <= sat_sum({{2{deriv_q[DATA_W-1]}}, deriv_q}
				- {{2{prod_frac[DATA_W-1]}}, prod_frac});
		if (ctrl.wr_ii)
			ii_q <= prod_frac;
		if (out_fire)
			drive_q <= sat_sum({{2{p_q[DATA_W-1]}}, p_q}
				+ {{2{prod_frac[DATA_W-1]}}, prod_frac}
				+ {{2{integ_q[DATA_W-1]}}, integ_q});
	end

	// controller state, updated when the result is issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deriv_q <= '0;
			integ_q <= '0;
			last_q  <= '0;
		end else if (out_fire) begin
			deriv_q <= prod_frac;
			integ_q <= sat_sum({{2{integ_q[DATA_W-1]}}, integ_q}
				+ {{2{ii_q[DATA_W-1]}}, ii_q});
			last_q  <= speed_q;
		end
	end

	// output request flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_fire)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

endmodule

/* design/pid_filtered_derivative.sv */
// pid_filtered_derivative: top level of the PID speed controller with a
// filtered derivative on the measurement; uses pfd_pkg, pfd_sequencer, pfd_datapath
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------
//   input    | in        | in_valid/in_stall  | measured_speed  (s32 Q16.16)
//   output   | out       | out_valid/out_stall| drive_value     (s32 Q16.16)
//   config   | in        | cfg_we             | cfg_index, cfg_data
//
// each request passes through one load step, four steps on the single
// shared 32x32 multiplier, one finishing step that forms the drive value
// the load step for a new request comes the cycle after the result is placed in the
// output register; while that result is stalled and another is ready, the program
// holds on its last step
// reset clears gains, setpoint and controller state to zero
module pid_filtered_derivative
	import pfd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [DATA_W-1:0] measured_speed,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] drive_value,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [DATA_W-1:0]        cfg_data
);

	ctrl_word_t ctrl;
	dp_status_t status;

	// only the load step takes a request
	assign in_stall = !ctrl.load;

	pfd_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.ctrl     (ctrl)
	);

	pfd_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.status         (status),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.measured_speed (measured_speed),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.drive_value    (drive_value)
	);

endmodule

/* bench/pfd_checker.sv */
// pfd_checker: watches the speed, drive and register ports of the filtered
// derivative PID controller, predicts every drive value and compares it
// depends on pfd_pkg for widths and register codes
module pfd_checker
	import pfd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic signed [DATA_W-1:0] measured_speed,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic signed [DATA_W-1:0] drive_value,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [DATA_W-1:0]        cfg_data,
	output int                       mismatches,
	output int                       outstanding
);

	typedef logic signed [DATA_W-1:0] q_word_t;

	localparam longint Q_HI = 64'sh0000_0000_7fff_ffff;
	localparam longint Q_LO = -64'sh0000_0000_8000_0000;

	// register copy
	q_word_t setpoint, prop_gain, deriv_in_gain, deriv_filt_gain, integ_gain;
	// controller state copy
	q_word_t deriv_state, integ_state, prev_speed;

	q_word_t drive_expected[$];
	int      fail_total = 0;

	assign mismatches = fail_total;

	// clamp an exact sum to the 32-bit range
	function automatic q_word_t clamp32(input longint v);
		if (v > Q_HI)
			return q_word_t'(Q_HI);
		if (v < Q_LO)
			return q_word_t'(Q_LO);
		return q_word_t'(v);
	endfunction

	// fixed-point product: floor of the full product, then clamp
	function automatic q_word_t fx_mul(input q_word_t a, input q_word_t b);
		longint prod;
		prod = longint'(a) * longint'(b);
		return clamp32(prod >>> FRAC_W);
	endfunction

	// one controller step on the local state, returns the drive value
	function automatic q_word_t advance_controller(input q_word_t speed);
		q_word_t err, p_val, delta, pre, drive;
		err   = clamp32(longint'(setpoint) - longint'(speed));
		p_val = fx_mul(err, prop_gain);
		delta = clamp32(longint'(speed) - longint'(prev_speed));
		pre   = clamp32(longint'(deriv_state) - longint'(fx_mul(delta, deriv_in_gain)));
		deriv_state = fx_mul(pre, deriv_filt_gain);
		drive = clamp32(longint'(p_val) + longint'(deriv_state) + longint'(integ_state));
		// integral acts one sample late
		integ_state = clamp32(longint'(integ_state) + longint'(fx_mul(err, integ_gain)));
		prev_speed  = speed;
		return drive;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		fail_total++;
	endtask

	// track register writes, predict on each accepted request, check each result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint        = '0;
			prop_gain       = '0;
			deriv_in_gain   = '0;
			deriv_filt_gain = '0;
			integ_gain      = '0;
			deriv_state     = '0;
			integ_state     = '0;
			prev_speed      = '0;
			drive_expected.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SETPOINT:   setpoint        = cfg_data;
					REG_PROP_GAIN:  prop_gain       = cfg_data;
					REG_DIN_GAIN:   deriv_in_gain   = cfg_data;
					REG_DFILT_GAIN: deriv_filt_gain = cfg_data;
					REG_INTEG_GAIN: integ_gain      = cfg_data;
					default: ;
				endcase
			end
			// results first: a result never comes from the request taken at the same edge
			if (out_valid && !out_stall) begin
				if (drive_expected.size() == 0)
					report_mismatch($sformatf("drive_value %0d with no request waiting",
						drive_value));
				else if (drive_value !== drive_expected[0]) begin
					report_mismatch($sformatf("drive_value %0d, predicted %0d",
						drive_value, drive_expected[0]));
					void'(drive_expected.pop_front());
				end else
					void'(drive_expected.pop_front());
			end
			if (in_valid && !in_stall)
				drive_expected.push_back(advance_controller(measured_speed));
			outstanding <= drive_expected.size();
		end
	end

endmodule

/* bench/testbench.sv */
// testbench: drives speed requests and register settings into the filtered
// derivative PID controller and gives the verdict; depends on pfd_pkg,
// pid_filtered_derivative and pfd_checker
module testbench;
	import pfd_pkg::*;

	localparam int NUM_CFG = 5;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS = 150;
	localparam int RANDOM_PHASES = 12;
	localparam logic [DATA_W-1:0] Q_MAX = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;
	localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;

	typedef enum int {G_ZERO, G_SMALL, G_FULL, G_LIMIT} gain_kind_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [DATA_W-1:0]    measured_speed = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [DATA_W-1:0]    drive_value;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0]    cfg_data = '0;
	logic                 calm = 1'b0;
	int                   mismatch_count;
	int                   results_owed;

	pid_filtered_derivative dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .measured_speed(measured_speed),
		.out_valid(out_valid), .out_stall(out_stall), .drive_value(drive_value),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	pfd_checker score (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .measured_speed(measured_speed),
		.out_valid(out_valid), .out_stall(out_stall), .drive_value(drive_value),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatch_count), .outstanding(results_owed)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// receiver back-pressure, none during the calm stretch
	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(99) < 17);

	// present one speed request and hold it until taken
	task automatic send_speed(input logic [DATA_W-1:0] speed);
		if (!calm && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		measured_speed <= speed;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// stop sending and let every outstanding drive value come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (results_owed == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all five registers, now and then with an ignored out-of-range write
	task automatic program_regs(input logic [DATA_W-1:0] sp, kp, kd1, kd2, ki);
		reg_idx_t          order [NUM_CFG];
		logic [DATA_W-1:0] vals [NUM_CFG];
		int                i;
		order = '{REG_SETPOINT, REG_PROP_GAIN, REG_DIN_GAIN, REG_DFILT_GAIN, REG_INTEG_GAIN};
		vals  = '{sp, kp, kd1, kd2, ki};
		for (i = 0; i < NUM_CFG; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= order[i];
			cfg_data  <= vals[i];
			@(posedge clk);
		end
		if ($urandom_range(1) == 1) begin
			cfg_index <= CFG_IDX_W'($urandom_range(NUM_CFG, 2 ** CFG_IDX_W - 1));
			cfg_data  <= $urandom;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_gain(input gain_kind_t kind);
		logic [DATA_W-1:0] limits [4];
		limits = '{Q_MAX, Q_MIN, Q_ONE, -Q_ONE};
		case (kind)
			G_ZERO:  return '0;
			// roughly plus or minus two
			G_SMALL: return int'($urandom_range(0, 262143)) - 131072;
			G_FULL:  return $urandom;
			default: return limits[2'($urandom_range(3))];
		endcase
	endfunction

	// speeds mostly near the target, some anywhere, some at the rails
	function automatic logic [DATA_W-1:0] pick_speed(input logic [DATA_W-1:0] sp);
		int roll;
		roll = $urandom_range(99);
		if (roll < 45)
			return sp + (int'($urandom_range(0, 524287)) - 262144);
		if (roll < 80)
			return $urandom;
		if (roll < 90)
			return ($urandom_range(1) == 1) ? Q_MAX : Q_MIN;
		return sp;
	endfunction

	initial begin
		logic [DATA_W-1:0] dir_a [11];
		logic [DATA_W-1:0] dir_b [9];
		logic [DATA_W-1:0] sp;
		gain_kind_t        kind;
		int                ph, n;

		dir_a = '{32'h0, 32'h1, 32'hffff_ffff, Q_MAX, Q_MIN, Q_MAX,
			32'h000a_0000, 32'h000a_0000, 32'hfff6_0000, 32'h1, 32'h0};
		dir_b = '{Q_MAX, Q_MIN, Q_MAX, 32'h0, 32'hffff_ffff, Q_MIN, Q_MIN, 32'h1, Q_MAX};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: every drive value is zero
		send_speed(Q_MAX);
		send_speed(Q_MIN);
		send_speed(32'h1234_5678);
		drain();

		// moderate gains, rail-to-rail speed steps and negative floor rounding
		program_regs(32'h000a_0000, Q_ONE, 32'h0000_8000, 32'h0000_c000, 32'h0000_4000);
		foreach (dir_a[i])
			send_speed(dir_a[i]);
		drain();

		// extreme gains and target: drive products and sums into saturation
		program_regs(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX);
		foreach (dir_b[i])
			send_speed(dir_b[i]);
		drain();

		// random phases, first ones with small gains so the state evolves slowly
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			calm = (ph == 5);
			kind = (ph < 2) ? G_SMALL : gain_kind_t'($urandom_range(3));
			sp = ($urandom_range(1) == 1) ? pick_gain(G_SMALL) << 4 : pick_gain(G_FULL);
			program_regs(sp,
				pick_gain(kind), pick_gain(kind),
				pick_gain((ph < 2) ? G_SMALL : gain_kind_t'($urandom_range(3))),
				pick_gain((ph < 2) ? G_SMALL : gain_kind_t'($urandom_range(3))));
			for (n = 0; n < PHASE_ITEMS; n++)
				send_speed(pick_speed(sp));
			drain();
		end
		calm = 1'b0;

		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// run limit
	initial begin
		#8000000;
		$display("tb: failure");
		$finish;
	end

endmodule
